// ===== hw/rtl/iek_pkg.sv =====
`default_nettype none

package iek_pkg;

  // field widths
  localparam int E_W         = 48;
  localparam int T_W         = 32;
  localparam int SLOT_W      = 10;
  localparam int SLICE_CNT_W = 11;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_KICK      = 2'd3;

  localparam logic signed [T_W-1:0]   FIRST_CENTER_RST  = 32'sd0;
  localparam logic [T_W-1:0]          INV_BIN_WIDTH_RST = 32'h0100_0000;
  localparam logic [SLICE_CNT_W-1:0]  SLICE_COUNT_RST   = 11'd2;
  localparam logic signed [T_W-1:0]   ACC_KICK_RST      = 32'sd0;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_KICK = 1'b1;

  // interpolation term magnitude limit and energy range
  localparam logic [60:0]           TERM_CLAMP = 61'h1000_0000_0000_0000;
  localparam logic signed [E_W-1:0] E_MAX      = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [E_W-1:0] E_MIN      = 48'sh8000_0000_0000;
  localparam logic signed [63:0]    SUM_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0]    SUM_MIN    = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    logic                    mode;
    logic [SLOT_W-1:0]       slot;
    logic signed [T_W-1:0]   voltage_value;
    logic signed [T_W-1:0]   center_value;
    logic signed [T_W-1:0]   particle_time;
    logic signed [E_W-1:0]   particle_energy;
    logic                    last_particle;
  } in_item_t;

  typedef struct packed {
    logic signed [E_W-1:0] new_energy;
    logic                  in_range;
    logic                  saturated;
    logic                  last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iek_stream_if.sv =====
`default_nettype none

interface iek_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iek_ram.sv =====
`default_nettype none

module iek_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/interpolated_energy_kick_top.sv =====
`default_nettype none

// piecewise-linear energy kick. a load item (mode 0) writes one slot of the
// voltage and bin-center tables; a kick item (mode 1) finds its bin as
// floor((time - first_center) * inv_bin_width), and when the bin lies in
// 0..slice_count-2 adds voltage[bin] plus the floored linear slope term
// toward voltage[bin+1]; acc_kick is always added and the new energy
// saturates to the signed 48-bit range. one kick item gives one result,
// a load item gives none. the block is an 11-stage pipeline that takes one
// item every cycle while the output side keeps up; empty stages close up
// while the output stalls, so the input keeps taking items until every
// stage is full. the tables sit in three registered-read rams (two copies
// of the voltage table, one per read address) that are written and read
// in the same stage, in item order, so a kick right after a load already
// sees the new entry. table contents are undefined until loaded; there is
// no clearing pass after reset.
// configuration may only change while the pipeline is empty.
module interpolated_energy_kick_top #(
  parameter int MAX_SLICES      = 1024,
  parameter int WIDTH_FRAC_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [iek_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [iek_pkg::CFG_DATA_W-1:0]   cfg_data,
  iek_stream_if.sink                            in_ch,
  iek_stream_if.source                          out_ch
);

  localparam int AW    = $clog2(MAX_SLICES);
  localparam int NSTG  = 11;
  localparam int F     = WIDTH_FRAC_BITS;
  localparam int BW    = 64 - F;   // bin index bits
  localparam int QW    = 96 - F;   // scaled term bits
  localparam int CNT_W = ($clog2(MAX_SLICES + 1) > iek_pkg::SLICE_CNT_W) ?
                         $clog2(MAX_SLICES + 1) : iek_pkg::SLICE_CNT_W;
  localparam int SW    = (AW > iek_pkg::SLOT_W) ? AW : iek_pkg::SLOT_W;

  // side data that rides along with each item
  typedef struct packed {
    logic signed [48:0] sum0;      // energy + acc_kick
    logic signed [31:0] t;
    logic signed [31:0] v0;
    logic               in_range;
    logic               neg;       // sign of the slope term
    logic               last;
  } carry_t;

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic signed [32:0] nx;
    nx = -x;
    return x[32] ? nx[31:0] : x[31:0];
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0]                   fc_r;
  logic [31:0]                          inv_r;
  logic [iek_pkg::SLICE_CNT_W-1:0]      slice_count_r;
  logic signed [31:0]                   acc_kick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r          <= iek_pkg::FIRST_CENTER_RST;
      inv_r         <= iek_pkg::INV_BIN_WIDTH_RST;
      slice_count_r <= iek_pkg::SLICE_COUNT_RST;
      acc_kick_r    <= iek_pkg::ACC_KICK_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        iek_pkg::CFG_FIRST_CENTER:  fc_r          <= cfg_data;
        iek_pkg::CFG_INV_BIN_WIDTH: inv_r         <= cfg_data;
        iek_pkg::CFG_SLICE_COUNT:   slice_count_r <= cfg_data[iek_pkg::SLICE_CNT_W-1:0];
        iek_pkg::CFG_ACC_KICK:      acc_kick_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage valid bits and ready chain; a stage takes new data when it is
  // empty or its item moves on, so bubbles close up during a stall
  // ---------------------------------------------------------------------
  logic [NSTG:1]   vld_r;
  logic [NSTG:1]   vld_nxt;
  logic [NSTG+1:1] rdy;
  logic            s3_mode_r;

  always_comb begin
    rdy[NSTG+1] = out_ch.ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[1] = in_ch.valid;
    for (int k = 2; k <= NSTG; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
    // load items end at the table write
    vld_nxt[4] = vld_r[3] && (s3_mode_r == iek_pkg::MODE_KICK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_ch.ready = rdy[1];

  // ---------------------------------------------------------------------
  // carried side data
  // ---------------------------------------------------------------------
  carry_t cr_r   [1:NSTG-1];
  carry_t cr_nxt [1:NSTG-1];

  logic signed [31:0] ram_v0;
  logic signed [31:0] ram_v1;
  logic signed [31:0] ram_c0;
  logic signed [32:0] d_c;
  logic signed [32:0] dv_c;
  logic               in_range_c;

  assign d_c  = 33'(cr_r[4].t) - 33'(ram_c0);
  assign dv_c = 33'(ram_v1) - 33'(ram_v0);

  always_comb begin
    cr_nxt[1].sum0     = 49'(in_ch.data.particle_energy) + 49'(acc_kick_r);
    cr_nxt[1].t        = in_ch.data.particle_time;
    cr_nxt[1].v0       = '0;
    cr_nxt[1].in_range = 1'b0;
    cr_nxt[1].neg      = 1'b0;
    cr_nxt[1].last     = in_ch.data.last_particle;
    for (int k = 2; k < NSTG; k++) begin
      cr_nxt[k] = cr_r[k-1];
    end
    cr_nxt[3].in_range = in_range_c;
    cr_nxt[5].v0       = ram_v0;
    cr_nxt[5].neg      = d_c[32] ^ dv_c[32];
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        cr_r[k] <= cr_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: capture item, offset from the first bin center
  // ---------------------------------------------------------------------
  logic                         s1_mode_r;
  logic [iek_pkg::SLOT_W-1:0]   s1_slot_r;
  logic signed [31:0]           s1_vv_r;
  logic signed [31:0]           s1_cv_r;
  logic signed [32:0]           s1_diff_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_mode_r <= in_ch.data.mode;
      s1_slot_r <= in_ch.data.slot;
      s1_vv_r   <= in_ch.data.voltage_value;
      s1_cv_r   <= in_ch.data.center_value;
      s1_diff_r <= 33'(in_ch.data.particle_time) - 33'(fc_r);
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: offset times bins per time unit
  // ---------------------------------------------------------------------
  logic                         s2_mode_r;
  logic [iek_pkg::SLOT_W-1:0]   s2_slot_r;
  logic signed [31:0]           s2_vv_r;
  logic signed [31:0]           s2_cv_r;
  logic [63:0]                  s2_prod_r;
  logic                         s2_dneg_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_mode_r <= s1_mode_r;
      s2_slot_r <= s1_slot_r;
      s2_vv_r   <= s1_vv_r;
      s2_cv_r   <= s1_cv_r;
      s2_prod_r <= s1_diff_r[31:0] * inv_r;
      s2_dneg_r <= s1_diff_r[32];
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: bin index, range check, table address
  // ---------------------------------------------------------------------
  logic [BW-1:0]    bin_c;
  logic [CNT_W-1:0] n_c;
  logic [SW-1:0]    slot_ext_c;
  logic [AW-1:0]    s3_addr_r;
  logic             s3_wr_ok_r;
  logic signed [31:0] s3_vv_r;
  logic signed [31:0] s3_cv_r;

  assign bin_c      = s2_prod_r[63:F];
  assign slot_ext_c = SW'(s2_slot_r);
  // slice count beyond the table depth acts as the table depth
  assign n_c = (CNT_W'(slice_count_r) > CNT_W'(MAX_SLICES)) ?
               CNT_W'(MAX_SLICES) : CNT_W'(slice_count_r);
  // negative offset is in range only with a zero bin width register (bin 0)
  assign in_range_c = (n_c >= CNT_W'(2)) &&
                      (s2_dneg_r ? (inv_r == '0) : (bin_c < BW'(n_c - CNT_W'(1))));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_mode_r  <= s2_mode_r;
      s3_addr_r  <= (s2_mode_r == iek_pkg::MODE_KICK) ? bin_c[AW-1:0] :
                                                        slot_ext_c[AW-1:0];
      s3_wr_ok_r <= 32'(s2_slot_r) < 32'(MAX_SLICES);
      s3_vv_r    <= s2_vv_r;
      s3_cv_r    <= s2_cv_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: table write for loads, table reads for kicks
  // ---------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] addr_next_c;

  assign ram_we      = vld_r[3] && rdy[4] && (s3_mode_r == iek_pkg::MODE_LOAD) && s3_wr_ok_r;
  assign addr_next_c = s3_addr_r + AW'(1);

  iek_ram #(.WIDTH(32), .DEPTH(MAX_SLICES)) u_volt_lo (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s3_addr_r),
    .wdata (s3_vv_r),
    .re    (rdy[4]),
    .raddr (s3_addr_r),
    .rdata (ram_v0)
  );

  iek_ram #(.WIDTH(32), .DEPTH(MAX_SLICES)) u_volt_hi (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s3_addr_r),
    .wdata (s3_vv_r),
    .re    (rdy[4]),
    .raddr (addr_next_c),
    .rdata (ram_v1)
  );

  iek_ram #(.WIDTH(32), .DEPTH(MAX_SLICES)) u_center (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s3_addr_r),
    .wdata (s3_cv_r),
    .re    (rdy[4]),
    .raddr (s3_addr_r),
    .rdata (ram_c0)
  );

  // ---------------------------------------------------------------------
  // stage 5: magnitudes of time-to-center and voltage step
  // ---------------------------------------------------------------------
  logic [31:0] s5_dmag_r;
  logic [31:0] s5_dvmag_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_dmag_r  <= mag33(d_c);
      s5_dvmag_r <= mag33(dv_c);
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: |dt| * |dv|
  // ---------------------------------------------------------------------
  logic [63:0] s6_p_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_p_r <= s5_dmag_r * s5_dvmag_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 7: two 32x32 partial products against the inverse bin width
  // ---------------------------------------------------------------------
  logic [63:0] s7_hi_r;
  logic [63:0] s7_lo_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_hi_r <= s6_p_r[63:32] * inv_r;
      s7_lo_r <= s6_p_r[31:0] * inv_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 8: combine partials into the full 96-bit product
  // ---------------------------------------------------------------------
  logic [95:0] s8_full_r;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_full_r <= {s7_hi_r, 32'b0} + {32'b0, s7_lo_r};
    end
  end

  // ---------------------------------------------------------------------
  // stage 9: drop fraction bits, clamp, decide the floor correction
  // ---------------------------------------------------------------------
  logic [QW-1:0] qw_c;
  logic          big_c;
  logic          rem_c;
  logic [60:0]   s9_q_r;
  logic          s9_inc_r;

  assign qw_c  = s8_full_r[95:F];
  assign big_c = qw_c > QW'(iek_pkg::TERM_CLAMP);
  assign rem_c = |s8_full_r[F-1:0];

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_q_r   <= big_c ? iek_pkg::TERM_CLAMP : qw_c[60:0];
      // negative term with a remainder rounds away from zero, unless at the clamp
      s9_inc_r <= cr_r[8].neg && rem_c && !big_c && (qw_c[60:0] != iek_pkg::TERM_CLAMP);
    end
  end

  // ---------------------------------------------------------------------
  // stage 10: signed term and the full sum
  // ---------------------------------------------------------------------
  logic signed [61:0] term_c;
  logic signed [63:0] sum_c;
  logic signed [63:0] s10_sum_r;

  // -(q + inc) written as ~q + !inc
  assign term_c = cr_r[9].neg ? signed'(~{1'b0, s9_q_r} + 62'(!s9_inc_r)) :
                                signed'({1'b0, s9_q_r});
  assign sum_c  = 64'(cr_r[9].sum0) +
                  (cr_r[9].in_range ? (64'(cr_r[9].v0) + 64'(term_c)) : 64'sd0);

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_sum_r <= sum_c;
    end
  end

  // ---------------------------------------------------------------------
  // stage 11: saturate into the output register
  // ---------------------------------------------------------------------
  logic               sat_hi_c;
  logic               sat_lo_c;
  iek_pkg::out_item_t out_r;

  assign sat_hi_c = s10_sum_r > iek_pkg::SUM_MAX;
  assign sat_lo_c = s10_sum_r < iek_pkg::SUM_MIN;

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      out_r.new_energy <= sat_hi_c ? iek_pkg::E_MAX :
                          sat_lo_c ? iek_pkg::E_MIN : s10_sum_r[47:0];
      out_r.in_range   <= cr_r[10].in_range;
      out_r.saturated  <= sat_hi_c || sat_lo_c;
      out_r.last       <= cr_r[10].last;
    end
  end

  assign out_ch.valid = vld_r[NSTG];
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  // a clipped result sits exactly on one of the range limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.saturated |->
      (out_ch.data.new_energy == iek_pkg::E_MAX ||
       out_ch.data.new_energy == iek_pkg::E_MIN))
    else $error("saturated result not at a range limit");

  // input only backs up when every stage is full and the output is stalled
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> ((&vld_r) && !out_ch.ready))
    else $error("input stalled with an empty stage");

  // no result right out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  import iek_pkg::*;

  // block parameters, kept equal to the top level defaults
  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC_BITS   = 24;

  localparam int HALF_PERIOD     = 5;
  localparam int PIPE_DRAIN      = 16;     // 11-stage pipeline plus margin
  localparam int END_DRAIN       = 32;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic signed [T_W-1:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [T_W-1:0] T_MAX = 32'sh7FFF_FFFF;

  // one row of the directed part: a register write or an item, with an
  // optional result typed in by hand
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  iek_stream_if #(.payload_t(in_item_t))  in_ch ();
  iek_stream_if #(.payload_t(out_item_t)) out_ch ();

  interpolated_energy_kick_top #(
    .MAX_SLICES      (TABLE_DEPTH),
    .WIDTH_FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // predictor copy of the registers and tables
  logic signed [T_W-1:0]   fc_reg     = FIRST_CENTER_RST;
  logic [T_W-1:0]          inv_reg    = INV_BIN_WIDTH_RST;
  logic [SLICE_CNT_W-1:0]  slices_reg = SLICE_COUNT_RST;
  logic signed [T_W-1:0]   kick_reg   = ACC_KICK_RST;
  logic signed [T_W-1:0]   volt_tab   [TABLE_DEPTH];
  logic signed [T_W-1:0]   center_tab [TABLE_DEPTH];
  bit                      slot_loaded [TABLE_DEPTH];

  out_item_t energies_due [$];
  step_row_t directed_steps [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_pct = 20;
  int stall_pct = 20;
  bit calm = 1'b0;

  // slice count as the block uses it
  function automatic logic [SLICE_CNT_W-1:0] slices_in_use();
    return (slices_reg > TABLE_DEPTH) ? SLICE_CNT_W'(TABLE_DEPTH) : slices_reg;
  endfunction

  // bin of a particle time; returns 1 when the interpolation applies
  function automatic bit locate_bin(logic signed [T_W-1:0] t, output logic [63:0] bin);
    logic signed [T_W:0] diff;
    logic [SLICE_CNT_W-1:0] n;
    bin = '0;
    n = slices_in_use();
    diff = {t[T_W-1], t} - {fc_reg[T_W-1], fc_reg};
    if (n < 2) return 1'b0;
    if (inv_reg == '0) return 1'b1;
    if (diff < 0) return 1'b0;
    bin = ({32'd0, diff[T_W-1:0]} * {32'd0, inv_reg}) >> FRAC_BITS;
    return bin <= 64'(n - 2);
  endfunction

  // floor(d * dv * inv / 2^frac), magnitude clamped to the term limit
  function automatic logic signed [63:0] slope_term(logic signed [T_W:0] d,
                                                    logic signed [T_W:0] dv);
    logic [T_W:0] md, mdv;
    logic [63:0] p;
    logic [127:0] full, q;
    bit neg;
    md = (d < 0) ? -d : d;
    mdv = (dv < 0) ? -dv : dv;
    neg = (d < 0) != (dv < 0);
    p = 64'(md) * 64'(mdv);
    full = 128'(p) * 128'(inv_reg);
    q = full >> FRAC_BITS;
    if (q > 128'(TERM_CLAMP)) q = 128'(TERM_CLAMP);
    else if (neg && full[FRAC_BITS-1:0] != '0) q = q + 1;
    if (q > 128'(TERM_CLAMP)) q = 128'(TERM_CLAMP);
    if (p == '0) return 64'sd0;
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic out_item_t kicked_particle(in_item_t it);
    out_item_t r;
    logic [63:0] bin;
    logic signed [63:0] sum;
    logic signed [T_W-1:0] t, v0, v1, c0;
    logic signed [T_W:0] d, dv;
    t = it.particle_time;
    r.in_range = locate_bin(t, bin);
    sum = $signed(it.particle_energy);
    sum = sum + kick_reg;
    if (r.in_range) begin
      v0 = volt_tab[bin];
      v1 = volt_tab[bin + 1];
      c0 = center_tab[bin];
      d = {t[T_W-1], t} - {c0[T_W-1], c0};
      dv = {v1[T_W-1], v1} - {v0[T_W-1], v0};
      sum = sum + v0 + slope_term(d, dv);
    end
    r.saturated = 1'b0;
    if (sum > SUM_MAX) begin
      sum = SUM_MAX;
      r.saturated = 1'b1;
    end
    if (sum < SUM_MIN) begin
      sum = SUM_MIN;
      r.saturated = 1'b1;
    end
    r.new_energy = sum[E_W-1:0];
    r.last = it.last_particle;
    return r;
  endfunction

  // every field random, the whole width
  function automatic in_item_t noise_item();
    in_item_t it;
    it.mode = $urandom;
    it.slot = $urandom;
    it.voltage_value = $urandom;
    it.center_value = $urandom;
    it.particle_time = $urandom;
    it.particle_energy = {$urandom, $urandom};
    it.last_particle = $urandom;
    return it;
  endfunction

  // random item aimed at the table span of the current settings
  function automatic in_item_t fresh_item();
    in_item_t it;
    logic [SLICE_CNT_W-1:0] n;
    logic [63:0] span;
    int unsigned roll, pick;
    it = noise_item();
    n = slices_in_use();
    span = (inv_reg == '0) ? 64'hFFFF_FFFF : ((64'(n) << FRAC_BITS) / inv_reg);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (roll < 25) begin
      // table load, mostly inside the slices in use
      it.mode = MODE_LOAD;
      if (pick < 7) it.slot = $urandom_range(0, (n == 0) ? 0 : n - 1);
      if (pick < 5) it.voltage_value = $urandom_range(0, 2000) - 1000;
      if (pick >= 3) it.center_value = fc_reg + $urandom_range(0, span[31:0]);
    end else begin
      it.mode = MODE_KICK;
      if (roll < 80) it.particle_time = fc_reg + $urandom_range(0, span[31:0]);
      else if (roll < 88) it.particle_time = fc_reg - $urandom_range(1, 4);
      // energies near both rails
      if (pick == 0) it.particle_energy = E_MAX - E_W'($urandom_range(0, 32'hFFFF_FFFF));
      else if (pick == 1) it.particle_energy = E_MIN + E_W'($urandom_range(0, 32'hFFFF_FFFF));
    end
    return it;
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_row_t load_row(logic [SLOT_W-1:0] slot, logic signed [T_W-1:0] v,
                                         logic signed [T_W-1:0] c);
    step_row_t s;
    s = '{default: '0};
    s.item.mode = MODE_LOAD;
    s.item.slot = slot;
    s.item.voltage_value = v;
    s.item.center_value = c;
    return s;
  endfunction

  function automatic step_row_t kick_row(logic signed [T_W-1:0] t, logic signed [E_W-1:0] e,
                                         logic lst);
    step_row_t s;
    s = '{default: '0};
    s.item.mode = MODE_KICK;
    s.item.particle_time = t;
    s.item.particle_energy = e;
    s.item.last_particle = lst;
    return s;
  endfunction

  function automatic step_row_t kick_row_typed(logic signed [T_W-1:0] t,
                                               logic signed [E_W-1:0] e, logic lst,
                                               logic signed [E_W-1:0] ne, logic inr,
                                               logic sat);
    step_row_t s;
    s = kick_row(t, e, lst);
    s.typed = 1'b1;
    s.want = '{new_energy: ne, in_range: inr, saturated: sat, last: lst};
    return s;
  endfunction

  // one handshake on the input side; called at a falling edge, returns at one
  task automatic drive_item(in_item_t it, bit typed, out_item_t want);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    // accepted at this edge: advance the predictor in item order
    if (it.mode == MODE_LOAD) begin
      volt_tab[it.slot] = it.voltage_value;
      center_tab[it.slot] = it.center_value;
      slot_loaded[it.slot] = 1'b1;
    end else begin
      energies_due.push_back(typed ? want : kicked_particle(it));
    end
    @(negedge clk);
  endtask

  // a kick that would read an empty table slot gets loads in front of it
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    logic [63:0] bin;
    in_item_t fill;
    if (it.mode == MODE_KICK && locate_bin(it.particle_time, bin)) begin
      for (int k = 0; k < 2; k++) begin
        if (!slot_loaded[bin + k]) begin
          fill = noise_item();
          fill.mode = MODE_LOAD;
          fill.slot = SLOT_W'(bin + k);
          drive_item(fill, 1'b0, '0);
        end
      end
    end
    drive_item(it, typed, want);
  endtask

  // register write, only with the pipeline empty
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (energies_due.size() != 0) @(negedge clk);
    // loads give no result and may still be in flight
    repeat (PIPE_DRAIN) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FIRST_CENTER:  fc_reg = val;
      CFG_INV_BIN_WIDTH: inv_reg = val;
      CFG_SLICE_COUNT:   slices_reg = val[SLICE_CNT_W-1:0];
      CFG_ACC_KICK:      kick_reg = val;
      default: ;
    endcase
  endtask

  // output side: ready drops in random bursts, none in the calm part
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // each result against the oldest expected one
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (energies_due.size() == 0) begin
        $error("result with nothing expected: new_energy %0d", $signed(out_ch.data.new_energy));
        mismatch_count++;
      end else begin
        want = energies_due.pop_front();
        if (out_ch.data.new_energy !== want.new_energy) begin
          $error("new_energy: expected %0d, got %0d", $signed(want.new_energy),
                 $signed(out_ch.data.new_energy));
          mismatch_count++;
        end
        if (out_ch.data.in_range !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, out_ch.data.in_range);
          mismatch_count++;
        end
        if (out_ch.data.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_ch.data.saturated);
          mismatch_count++;
        end
        if (out_ch.data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.data.last);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] fc_pick, inv_pick, slices_pick, kick_pick;
    int unsigned roll;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;

    // directed rows: reset settings first
    directed_steps.push_back(kick_row_typed(-32'sd1, 48'sd0, 1'b0, 48'sd0, 1'b0, 1'b0));
    directed_steps.push_back(kick_row_typed(T_MIN, E_MAX, 1'b1, E_MAX, 1'b0, 1'b0));
    directed_steps.push_back(kick_row_typed(T_MAX, E_MIN, 1'b0, E_MIN, 1'b0, 1'b0));
    // extreme kicks clip at both rails
    directed_steps.push_back(cfg_row(CFG_ACC_KICK, 32'h7FFF_FFFF));
    directed_steps.push_back(kick_row_typed(-32'sd1, E_MAX, 1'b1, E_MAX, 1'b0, 1'b1));
    directed_steps.push_back(cfg_row(CFG_ACC_KICK, 32'h8000_0000));
    directed_steps.push_back(kick_row_typed(-32'sd1, E_MIN, 1'b0, E_MIN, 1'b0, 1'b1));
    directed_steps.push_back(kick_row_typed(-32'sd1, 48'sd5, 1'b0, -48'sd2147483643,
                                            1'b0, 1'b0));
    directed_steps.push_back(cfg_row(CFG_ACC_KICK, 32'h0000_0000));
    // particle right on the first center reads voltage[0] only
    directed_steps.push_back(load_row(10'd0, 32'sd1000, 32'sd0));
    directed_steps.push_back(load_row(10'd1, 32'sd3000, 32'sd0));
    directed_steps.push_back(kick_row_typed(32'sd0, 48'sd0, 1'b1, 48'sd1000, 1'b1, 1'b0));
    directed_steps.push_back(kick_row_typed(32'sd1, 48'sd0, 1'b0, 48'sd0, 1'b0, 1'b0));
    // slice count below two: no bin in range
    directed_steps.push_back(cfg_row(CFG_SLICE_COUNT, 32'd0));
    directed_steps.push_back(kick_row_typed(32'sd0, 48'sd7, 1'b0, 48'sd7, 1'b0, 1'b0));
    directed_steps.push_back(cfg_row(CFG_SLICE_COUNT, 32'd1));
    directed_steps.push_back(kick_row_typed(32'sd0, 48'sd7, 1'b1, 48'sd7, 1'b0, 1'b0));
    // slice count above the table depth, huge term clamped at the top bin
    directed_steps.push_back(cfg_row(CFG_SLICE_COUNT, 32'd2047));
    directed_steps.push_back(load_row(10'd1022, T_MIN, T_MIN));
    directed_steps.push_back(load_row(10'd1023, T_MAX, T_MAX));
    directed_steps.push_back(kick_row(32'sd1022, 48'sd0, 1'b0));
    directed_steps.push_back(kick_row_typed(32'sd1023, 48'sd0, 1'b0, 48'sd0, 1'b0, 1'b0));
    // zero bin width: everything lands in bin 0
    directed_steps.push_back(cfg_row(CFG_SLICE_COUNT, 32'd2));
    directed_steps.push_back(cfg_row(CFG_INV_BIN_WIDTH, 32'd0));
    directed_steps.push_back(cfg_row(CFG_FIRST_CENTER, 32'h7FFF_FFFF));
    directed_steps.push_back(kick_row(T_MIN, E_MIN, 1'b0));
    // widest bin width, negative term floored
    directed_steps.push_back(cfg_row(CFG_INV_BIN_WIDTH, 32'hFFFF_FFFF));
    directed_steps.push_back(cfg_row(CFG_FIRST_CENTER, 32'h8000_0000));
    directed_steps.push_back(kick_row(T_MIN, 48'sd0, 1'b1));
    directed_steps.push_back(load_row(10'd0, T_MAX, T_MAX));
    directed_steps.push_back(load_row(10'd1, T_MIN, 32'sd0));
    directed_steps.push_back(kick_row(T_MIN, E_MAX, 1'b0));
    directed_steps.push_back(kick_row(T_MIN + 32'sd1, 48'sd0, 1'b0));
    // narrowest nonzero bin width
    directed_steps.push_back(cfg_row(CFG_INV_BIN_WIDTH, 32'd1));
    directed_steps.push_back(cfg_row(CFG_FIRST_CENTER, 32'd0));
    directed_steps.push_back(kick_row(T_MAX, 48'sd0, 1'b1));

    // synchronous reset held, then released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg)
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      else
        send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
    end

    // random phases, each with its own settings; the first two at the extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        fc_pick = 32'h8000_0000;
        inv_pick = 32'd0;
        slices_pick = 32'd2;
        kick_pick = 32'h8000_0000;
      end else if (ph == 1) begin
        fc_pick = 32'h7FFF_FFFF;
        inv_pick = 32'hFFFF_FFFF;
        slices_pick = 32'd1024;
        kick_pick = 32'h7FFF_FFFF;
      end else begin
        roll = $urandom_range(0, 3);
        fc_pick = (roll == 0) ? $urandom_range(0, 2000) - 1000 : $urandom;
        roll = $urandom_range(0, 3);
        case (roll)
          0: inv_pick = INV_BIN_WIDTH_RST;
          1: inv_pick = $urandom >> $urandom_range(0, 31);
          2: inv_pick = 32'd1 << $urandom_range(14, 30);
          default: inv_pick = $urandom;
        endcase
        // mostly small slice counts, a few large or degenerate ones
        roll = $urandom_range(0, 9);
        case (roll)
          0: slices_pick = $urandom_range(0, 1) ? 32'd1 : 32'd2047;
          1: slices_pick = 32'd1024;
          2: slices_pick = $urandom_range(2, 2047);
          default: slices_pick = $urandom_range(2, 16);
        endcase
        roll = $urandom_range(0, 3);
        kick_pick = (roll == 0) ? 32'd0 : (roll == 1) ? $urandom_range(0, 200) - 100 : $urandom;
      end
      write_reg(CFG_FIRST_CENTER, fc_pick);
      write_reg(CFG_INV_BIN_WIDTH, inv_pick);
      write_reg(CFG_SLICE_COUNT, slices_pick);
      write_reg(CFG_ACC_KICK, kick_pick);

      // the last phases run without gaps or stalls
      calm = (ph >= PHASES - 2);
      roll = $urandom_range(0, 2);
      gap_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;
      roll = $urandom_range(0, 2);
      stall_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;

      repeat (ITEMS_PER_PHASE) send_item(fresh_item(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (energies_due.size() != 0) @(negedge clk);
    repeat (END_DRAIN) @(negedge clk);

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
